// File: design/ecn_trim_rate_controller_core_defines.svh
// assertion macros shared by the rate controller checker
`ifndef ECN_TRIM_RATE_CONTROLLER_CORE_DEFINES_SVH
`define ECN_TRIM_RATE_CONTROLLER_CORE_DEFINES_SVH

// concurrent assertion on an explicit clock and active-low reset
`define ECNT_ASSERT(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// same, on the block clock and reset
`define ECNT_ASSERT_CLK(lbl, prop, msg) `ECNT_ASSERT(lbl, clk, rst_n, prop, msg)

`endif

// File: design/ecnt_pkg.sv
// shared types and constants of the ecn trim rate controller
`timescale 1ns / 1ps
package ecnt_pkg;

  localparam int DEF_COUNT_BITS = 16;
  localparam int DEF_FRAC_BITS  = 16;

  // increase run counter
  localparam int RUN_W = 5;
  localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET = 3'd0,
    REG_STEP   = 3'd1,
    REG_GAIN   = 3'd2,
    REG_FLOOR  = 3'd3,
    REG_WEIGHT = 3'd4
  } cfg_reg_t;

  // operand select of the shared multiplier
  typedef enum logic [1:0] {
    MUL_EWMA_OLD,
    MUL_EWMA_NEW,
    MUL_TERM,
    MUL_RATE
  } mul_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic     capture;
    logic     prep;
    logic     div_go;
    logic     div_cut;
    logic     frac_load;
    logic     cut_load;
    logic     mul_go;
    mul_sel_t mul_sel;
    logic     acc_load;
    logic     g_load;
    logic     factor_load;
    logic     rate_load;
    logic     finish;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic count_err;
    logic full_zero;
    logic other_zero;
    logic div_done;
    logic decrease;
    logic out_free;
  } status_t;

endpackage

// File: design/ecn_trim_rate_controller_core.sv
// top level of the ecn trim rate controller
// Usage:
//   in_*  : one beat per control interval, wrapping snapshots of the received,
//           marked, last-hop trimmed and elsewhere trimmed packet counters.
//   out_* : one beat per input beat: new rate and congestion estimate (Q.FRAC_BITS,
//           full scale 2^FRAC_BITS) and a count error flag.
//   cfg_* : register writes (index, data), always ready; write only while idle.
// Timing:
//   one tick at a time; an input beat on a count error goes straight to its
//   output beat, otherwise the tick uses the shared serial divider, one
//   quotient bit a cycle, run for the marked fraction and the elsewhere-trim
//   share, plus one shared multiplier used for four products in turn.
//   in_ready rises with the output beat, so no new beat is taken while a
//   tick is in flight.
// Reset: rate goes to full scale, estimate, run count and snapshots to zero,
//   registers to their defaults; in_ready comes up in the cycle after reset.
// Stall: a result waits in the output register; the next beat is accepted and
//   processed, and its result holds until the waiting beat is taken.
`timescale 1ns / 1ps
module ecn_trim_rate_controller_core import ecnt_pkg::*; #(
  parameter int COUNT_BITS = DEF_COUNT_BITS,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [FRAC_BITS:0]    cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COUNT_BITS-1:0] in_received_total,
  input  logic [COUNT_BITS-1:0] in_marked_total,
  input  logic [COUNT_BITS-1:0] in_lasthop_trim_total,
  input  logic [COUNT_BITS-1:0] in_other_trim_total,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [FRAC_BITS:0]    out_new_rate,
  output logic [FRAC_BITS:0]    out_congestion_estimate,
  output logic                  out_count_error
);

  cmd_t    cmd;
  status_t status;

  // registers take a write in any cycle
  assign cfg_ready = 1'b1;

  // sequencer
  ecnt_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  // arithmetic and state
  ecnt_dp #(
    .COUNT_BITS(COUNT_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .status                 (status),
    .cfg_valid              (cfg_valid),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .in_received_total      (in_received_total),
    .in_marked_total        (in_marked_total),
    .in_lasthop_trim_total  (in_lasthop_trim_total),
    .in_other_trim_total    (in_other_trim_total),
    .out_ready              (out_ready),
    .out_valid              (out_valid),
    .out_new_rate           (out_new_rate),
    .out_congestion_estimate(out_congestion_estimate),
    .out_count_error        (out_count_error)
  );

endmodule

// File: design/ecnt_div.sv
// serial restoring divider, one quotient bit per cycle, numerator not above divisor
`timescale 1ns / 1ps
module ecnt_div import ecnt_pkg::*; #(
  parameter int COUNT_BITS = DEF_COUNT_BITS,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [COUNT_BITS-1:0] num,
  input  logic [COUNT_BITS-1:0] den,
  output logic [FRAC_BITS:0]    quo,
  output logic                  done
);

  localparam int STEPS = FRAC_BITS + 1;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [COUNT_BITS:0]   rem_r;
  logic [COUNT_BITS-1:0] den_r;
  logic [FRAC_BITS:0]    quo_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  busy_r;
  logic                  done_r;

  logic                  ge;
  logic [COUNT_BITS:0]   rem_sub;

  // trial subtract of the divisor
  assign ge      = rem_r >= {1'b0, den_r};
  assign rem_sub = ge ? (rem_r - {1'b0, den_r}) : rem_r;

  // iteration control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, num};
      den_r <= den;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= {rem_sub[COUNT_BITS-1:0], 1'b0};
      quo_r <= {quo_r[FRAC_BITS-1:0], ge};
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

// File: design/ecnt_ctrl.sv
// sequencer of one control tick: check, two divisions, ewma and decrease products
`timescale 1ns / 1ps
module ecnt_ctrl import ecnt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DIV_FRAC,
    S_DIV_CUT,
    S_MUL_E1,
    S_MUL_E2,
    S_MUL_E3,
    S_MUL_D1,
    S_MUL_D2,
    S_MUL_D3,
    S_MUL_D4,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.capture = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.prep = 1'b1;
        if (status.count_err) begin
          state_nxt = S_FINISH;
        end else if (!status.full_zero) begin
          cmd.div_go = 1'b1;
          state_nxt  = S_DIV_FRAC;
        end else if (!status.other_zero) begin
          cmd.div_go  = 1'b1;
          cmd.div_cut = 1'b1;
          state_nxt   = S_DIV_CUT;
        end else begin
          state_nxt = S_MUL_E1;
        end
      end
      S_DIV_FRAC: begin
        if (status.div_done) begin
          cmd.frac_load = 1'b1;
          if (!status.other_zero) begin
            cmd.div_go  = 1'b1;
            cmd.div_cut = 1'b1;
            state_nxt   = S_DIV_CUT;
          end else begin
            state_nxt = S_MUL_E1;
          end
        end
      end
      S_DIV_CUT: begin
        cmd.div_cut = 1'b1;
        if (status.div_done) begin
          cmd.cut_load = 1'b1;
          state_nxt    = S_MUL_E1;
        end
      end
      S_MUL_E1: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MUL_EWMA_OLD;
        state_nxt   = S_MUL_E2;
      end
      S_MUL_E2: begin
        cmd.mul_go   = 1'b1;
        cmd.mul_sel  = MUL_EWMA_NEW;
        cmd.acc_load = 1'b1;
        state_nxt    = S_MUL_E3;
      end
      S_MUL_E3: begin
        cmd.g_load = 1'b1;
        state_nxt  = S_MUL_D1;
      end
      S_MUL_D1: begin
        if (status.decrease) begin
          cmd.mul_go  = 1'b1;
          cmd.mul_sel = MUL_TERM;
          state_nxt   = S_MUL_D2;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_MUL_D2: begin
        cmd.factor_load = 1'b1;
        state_nxt       = S_MUL_D3;
      end
      S_MUL_D3: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MUL_RATE;
        state_nxt   = S_MUL_D4;
      end
      S_MUL_D4: begin
        cmd.rate_load = 1'b1;
        state_nxt     = S_FINISH;
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_ready = in_ready_r;

endmodule

// File: design/ecnt_dp.sv
// datapath: config and state registers, deltas, shared divider and multiplier, output beat
`timescale 1ns / 1ps
module ecnt_dp import ecnt_pkg::*; #(
  parameter int COUNT_BITS = DEF_COUNT_BITS,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output status_t               status,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [FRAC_BITS:0]    cfg_data,
  input  logic [COUNT_BITS-1:0] in_received_total,
  input  logic [COUNT_BITS-1:0] in_marked_total,
  input  logic [COUNT_BITS-1:0] in_lasthop_trim_total,
  input  logic [COUNT_BITS-1:0] in_other_trim_total,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [FRAC_BITS:0]    out_new_rate,
  output logic [FRAC_BITS:0]    out_congestion_estimate,
  output logic                  out_count_error
);

  localparam int CW  = COUNT_BITS;
  localparam int QW  = FRAC_BITS + 1;
  localparam int MW  = FRAC_BITS + 2;
  localparam int SW  = FRAC_BITS + 3;
  localparam int PW  = 2 * MW;
  localparam int SHW = QW + (1 << RUN_W) - 1;

  localparam int unsigned ONE_I = 1 << FRAC_BITS;
  localparam logic [QW-1:0] ONE        = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [QW-1:0] TARGET_RST = QW'((ONE_I * 3 + 5) / 10);
  localparam logic [QW-1:0] STEP_RST   = QW'(ONE_I / 100);
  localparam logic [QW-1:0] GAIN_RST   = QW'(ONE_I / 2);
  localparam logic [QW-1:0] FLOOR_RST  = QW'(ONE_I / 100);
  localparam logic [QW-1:0] WEIGHT_RST = QW'(ONE_I / 2);

  // configuration registers
  logic [QW-1:0] cfg_target_r, cfg_step_r, cfg_gain_r, cfg_floor_r, cfg_weight_r;

  // persistent state
  logic [QW-1:0]    rate_r, ewma_r;
  logic [RUN_W-1:0] run_r;
  logic [CW-1:0]    prev_rcv_r, prev_mrk_r, prev_lh_r, prev_ot_r;

  // per-tick working registers
  logic [CW-1:0]        cur_rcv_r, cur_mrk_r, cur_lh_r, cur_ot_r;
  logic [QW-1:0]        frac_r, g_r;
  logic signed [SW-1:0] rate_t_r;
  logic                 cut_r;
  logic signed [PW-1:0] prod_r, acc_r;
  logic signed [MW-1:0] factor_r;

  // output beat
  logic          out_valid_r;
  logic [QW-1:0] out_rate_r, out_ewma_r;
  logic          out_err_r;

  // deltas and count check
  logic [CW-1:0]   d_rcv, d_mrk, d_lh, d_ot, full;
  logic [CW+1:0]   chk_sum;
  logic            count_err;

  assign d_rcv   = cur_rcv_r - prev_rcv_r;
  assign d_mrk   = cur_mrk_r - prev_mrk_r;
  assign d_lh    = cur_lh_r - prev_lh_r;
  assign d_ot    = cur_ot_r - prev_ot_r;
  assign chk_sum = {2'b00, d_mrk} + {2'b00, d_lh} + {2'b00, d_ot};
  assign count_err = chk_sum > {2'b00, d_rcv};
  assign full    = d_rcv - d_lh - d_ot;

  // shared divider: marked fraction, then other-trim share
  logic [CW-1:0] div_num, div_den;
  logic [QW-1:0] div_quo;
  logic          div_done;

  assign div_num = cmd.div_cut ? d_ot : d_mrk;
  assign div_den = cmd.div_cut ? d_rcv : full;

  ecnt_div #(
    .COUNT_BITS(COUNT_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmd.div_go),
    .num  (div_num),
    .den  (div_den),
    .quo  (div_quo),
    .done (div_done)
  );

  // shared multiplier operand select
  logic [QW-1:0]        w_eff, one_minus_w, g_diff;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p;

  assign w_eff       = (cfg_weight_r > ONE) ? ONE : cfg_weight_r;
  assign one_minus_w = ONE - w_eff;
  assign g_diff      = g_r - cfg_target_r;

  always_comb begin
    case (cmd.mul_sel)
      MUL_EWMA_OLD: begin
        mul_a = $signed({1'b0, ewma_r});
        mul_b = $signed({1'b0, one_minus_w});
      end
      MUL_EWMA_NEW: begin
        mul_a = $signed({1'b0, w_eff});
        mul_b = $signed({1'b0, frac_r});
      end
      MUL_TERM: begin
        mul_a = $signed({1'b0, g_diff});
        mul_b = $signed({1'b0, cfg_gain_r});
      end
      MUL_RATE: begin
        mul_a = rate_t_r[MW-1:0];
        mul_b = factor_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // product post-processing
  logic signed [PW-1:0] ewma_sum, rate_shift;
  logic [QW-1:0]        term;
  logic signed [MW-1:0] factor_nxt;

  assign ewma_sum   = acc_r + prod_r;
  assign term       = prod_r[FRAC_BITS +: QW];
  assign factor_nxt = $signed({1'b0, ONE}) - $signed({1'b0, term});
  assign rate_shift = prod_r >>> FRAC_BITS;

  // additive increase, saturated well above full rate
  logic [SHW-1:0]       step_wide;
  logic                 step_big;
  logic [SW-2:0]        inc_mag;
  logic signed [SW-1:0] rate_inc, rate_pre, rate_lo, rate_fin, floor_s, one_s;
  logic [RUN_W-1:0]     run_nxt;

  assign step_wide = {{(SHW-QW){1'b0}}, cfg_step_r} << run_r;
  assign step_big  = |step_wide[SHW-1:FRAC_BITS+1];

  always_comb begin
    if (d_mrk != '0) begin
      inc_mag = {1'b0, cfg_step_r};
    end else if (step_big) begin
      inc_mag = {1'b1, {(FRAC_BITS+1){1'b0}}};
    end else begin
      inc_mag = {1'b0, step_wide[FRAC_BITS:0]};
    end
  end

  assign rate_inc = rate_t_r + $signed({1'b0, inc_mag});
  assign rate_pre = cut_r ? rate_t_r : rate_inc;
  assign floor_s  = $signed({2'b00, cfg_floor_r});
  assign one_s    = $signed({2'b00, ONE});
  assign rate_lo  = (rate_pre < floor_s) ? floor_s : rate_pre;
  assign rate_fin = (rate_lo > one_s) ? one_s : rate_lo;
  assign run_nxt  = cut_r ? '0 : ((run_r == RUN_MAX) ? RUN_MAX : run_r + 1'b1);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_target_r <= TARGET_RST;
      cfg_step_r   <= STEP_RST;
      cfg_gain_r   <= GAIN_RST;
      cfg_floor_r  <= FLOOR_RST;
      cfg_weight_r <= WEIGHT_RST;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_TARGET: cfg_target_r <= cfg_data;
        REG_STEP:   cfg_step_r   <= cfg_data;
        REG_GAIN:   cfg_gain_r   <= cfg_data;
        REG_FLOOR:  cfg_floor_r  <= cfg_data;
        REG_WEIGHT: cfg_weight_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // controller state, committed at the end of a good tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r     <= ONE;
      ewma_r     <= '0;
      run_r      <= '0;
      prev_rcv_r <= '0;
      prev_mrk_r <= '0;
      prev_lh_r  <= '0;
      prev_ot_r  <= '0;
    end else if (cmd.finish && !count_err) begin
      rate_r     <= rate_fin[QW-1:0];
      ewma_r     <= g_r;
      run_r      <= run_nxt;
      prev_rcv_r <= cur_rcv_r;
      prev_mrk_r <= cur_mrk_r;
      prev_lh_r  <= cur_lh_r;
      prev_ot_r  <= cur_ot_r;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_rcv_r <= in_received_total;
      cur_mrk_r <= in_marked_total;
      cur_lh_r  <= in_lasthop_trim_total;
      cur_ot_r  <= in_other_trim_total;
    end
    if (cmd.prep) begin
      frac_r   <= '0;
      rate_t_r <= $signed({2'b00, rate_r});
      cut_r    <= 1'b0;
    end
    if (cmd.frac_load) begin
      frac_r <= div_quo;
    end
    if (cmd.cut_load) begin
      rate_t_r <= rate_t_r - $signed({2'b00, div_quo});
      cut_r    <= 1'b1;
    end
    if (cmd.mul_go) begin
      prod_r <= mul_p;
    end
    if (cmd.acc_load) begin
      acc_r <= prod_r;
    end
    if (cmd.g_load) begin
      g_r <= ewma_sum[FRAC_BITS +: QW];
    end
    if (cmd.factor_load) begin
      factor_r <= factor_nxt;
    end
    if (cmd.rate_load) begin
      rate_t_r <= rate_shift[SW-1:0];
      cut_r    <= 1'b1;
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (count_err) begin
        out_rate_r <= rate_r;
        out_ewma_r <= ewma_r;
        out_err_r  <= 1'b1;
      end else begin
        out_rate_r <= rate_fin[QW-1:0];
        out_ewma_r <= g_r;
        out_err_r  <= 1'b0;
      end
    end
  end

  // status to the controller
  assign status.count_err  = count_err;
  assign status.full_zero  = (full == '0);
  assign status.other_zero = (d_ot == '0);
  assign status.div_done   = div_done;
  assign status.decrease   = (g_r > cfg_target_r) && (cfg_gain_r != '0);
  assign status.out_free   = !out_valid_r || out_ready;

  assign out_valid               = out_valid_r;
  assign out_new_rate            = out_rate_r;
  assign out_congestion_estimate = out_ewma_r;
  assign out_count_error         = out_err_r;

endmodule

// File: design/ecnt_chk.sv
// port-level checker of the rate controller and its bind
`timescale 1ns / 1ps
`include "ecn_trim_rate_controller_core_defines.svh"
module ecnt_chk import ecnt_pkg::*; #(
  parameter int COUNT_BITS = DEF_COUNT_BITS,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [FRAC_BITS:0]    cfg_data,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic [COUNT_BITS-1:0] in_received_total,
  input logic [COUNT_BITS-1:0] in_marked_total,
  input logic [COUNT_BITS-1:0] in_lasthop_trim_total,
  input logic [COUNT_BITS-1:0] in_other_trim_total,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [FRAC_BITS:0]    out_new_rate,
  input logic [FRAC_BITS:0]    out_congestion_estimate,
  input logic                  out_count_error
);

  // output beat fields and full-scale overflow flags
  logic [2*FRAC_BITS+2:0] out_beat;
  logic                   rate_over, ewma_over;

  assign out_beat  = {out_new_rate, out_congestion_estimate, out_count_error};
  assign rate_over = out_new_rate[FRAC_BITS] && (out_new_rate[FRAC_BITS-1:0] != '0);
  assign ewma_over = out_congestion_estimate[FRAC_BITS] &&
                     (out_congestion_estimate[FRAC_BITS-1:0] != '0);

  // a stalled output beat holds
  `ECNT_ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_beat), "output beat changed while stalled")

  // one tick at a time: no input beat right after one is taken
  `ECNT_ASSERT_CLK(a_one_tick, in_valid && in_ready |=> !in_ready, "input taken while a tick is in flight")

  // rate never above full scale
  `ECNT_ASSERT_CLK(a_rate_max, out_valid |-> !rate_over, "rate above full scale")

  // estimate never above full scale
  `ECNT_ASSERT_CLK(a_ewma_max, out_valid |-> !ewma_over, "estimate above full scale")

endmodule

bind ecn_trim_rate_controller_core ecnt_chk #(
  .COUNT_BITS(COUNT_BITS),
  .FRAC_BITS (FRAC_BITS)
) u_chk (.*);
